@@ design/bsw_pkg.sv @@
// Shared types, widths and constants for the band-limited saw oscillator.
// Also holds the fixed-point sine used to fill the wavetable.
// No dependencies.
package bsw_pkg;

  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned FREQ_W   = 24;
  localparam int unsigned PPH_W    = 24;
  localparam int unsigned PSET_W   = 24;
  localparam int unsigned SAMPLE_W = 16;

  // Default phase increment per hertz (48 kHz sample rate)
  localparam logic [PPH_W-1:0] PPH_RESET = 24'd89478;

  // Polynomial sine coefficients, Q30
  localparam longint unsigned SIN_A   = 64'd1686629713;
  localparam longint unsigned SIN_B   = 64'd688904866;
  localparam longint unsigned SIN_C   = 64'd76016977;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  typedef enum logic {
    FUNC_SAMPLE    = 1'b0,
    FUNC_SET_PHASE = 1'b1
  } func_e;

  // Status of the interpolation stage toward the phase stage and the top
  typedef struct packed {
    logic s2_valid;
    logic ready;
  } stage_t;

  // Q30 sine of a 32-bit phase; quarter-wave fold plus odd polynomial
  function automatic longint sine_q30(input logic [PHASE_W-1:0] p);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x = {34'd0, p[29:0]};
    if (p[30]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >> 30;
    t  = (SIN_C * x2) >> 30;
    t  = SIN_B - t;
    t  = (t * x2) >> 30;
    t  = SIN_A - t;
    t  = (t * x) >> 30;
    sine_q30 = p[31] ? -longint'(t) : longint'(t);
  endfunction

endpackage

@@ design/bandlimited_saw_wavetable_osc.sv @@
// Top level of the band-limited sawtooth wavetable oscillator.
// Instantiates bsw_phase, bsw_saw_rom and bsw_interp; uses bsw_pkg.
//
// Input channel (valid_i / stall_o): one word per sample request or phase
// load. func_i selects between emitting one sample at frequency freq_hz_i
// (signed Q16.8 Hz) and loading the phase from phase_set_i (0.24 cycle);
// a phase load produces no output word.
// Output channel (valid_o / stall_i): one signed Q2.14 sample per sample
// request, in request order.
// Configuration: cfg_we_i writes cfg_wdata_i into the phase increment per
// hertz; write it only while no words are in flight.
// A sample word passes the input register, the table read and the output
// register, in that order, before it is presented on valid_o.
// Throughput: one word per cycle while the output is not stalled, set by
// the accumulator loop around the registered 24x24 product and a 32-bit add.
// Reset clears the phase to zero, the increment to 89478 and empties the
// pipeline. A stalled output holds its word; the stages behind it keep
// filling until all three are full, then stall_o rises.
module bandlimited_saw_wavetable_osc #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned HARMONICS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic                                 func_i,
  input  logic signed [bsw_pkg::FREQ_W-1:0]    freq_hz_i,
  input  logic [bsw_pkg::PSET_W-1:0]           phase_set_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [bsw_pkg::SAMPLE_W-1:0]  sample_o,
  input  logic                                 cfg_we_i,
  input  logic [bsw_pkg::PPH_W-1:0]            cfg_wdata_i
);

  localparam int unsigned AW     = $clog2(TABLE_SIZE);
  localparam int unsigned FRAC_W = bsw_pkg::PHASE_W - AW;

  logic [bsw_pkg::PPH_W-1:0]            pph_q;
  logic                                 in_ready;
  logic                                 load;
  logic [AW-1:0]                        addr_a;
  logic [AW-1:0]                        addr_b;
  logic [FRAC_W-1:0]                    frac;
  logic signed [bsw_pkg::SAMPLE_W-1:0]  data_a;
  logic signed [bsw_pkg::SAMPLE_W-1:0]  data_b;
  bsw_pkg::stage_t                      stage;

  // Phase increment register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pph_q <= bsw_pkg::PPH_RESET;
    end else if (cfg_we_i) begin
      pph_q <= cfg_wdata_i;
    end
  end

  bsw_phase #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .func_i      (bsw_pkg::func_e'(func_i)),
    .freq_hz_i   (freq_hz_i),
    .phase_set_i (phase_set_i),
    .pph_i       (pph_q),
    .stage_i     (stage),
    .in_ready_o  (in_ready),
    .load_o      (load),
    .addr_a_o    (addr_a),
    .addr_b_o    (addr_b),
    .frac_o      (frac)
  );

  bsw_saw_rom #(
    .TABLE_SIZE (TABLE_SIZE),
    .HARMONICS  (HARMONICS)
  ) u_rom (
    .clk_i    (clk_i),
    .rd_en_i  (load),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .data_a_o (data_a),
    .data_b_o (data_b)
  );

  bsw_interp #(
    .FRAC_W (FRAC_W)
  ) u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .frac_i   (frac),
    .a_i      (data_a),
    .b_i      (data_b),
    .stall_i  (stall_i),
    .stage_o  (stage),
    .valid_o  (valid_o),
    .sample_o (sample_o)
  );

  assign stall_o = !in_ready;

  // An empty output register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with empty output register");

  // A table read always lands in stage two
  a_load_fills_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> stage.s2_valid)
    else $error("table read lost before interpolation");

  // An empty output register always takes the pending stage-two word
  a_s2_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.s2_valid && !valid_o |=> valid_o)
    else $error("stage-two word not moved to output");

endmodule

@@ design/bsw_saw_rom.sv @@
// Sawtooth wavetable ROM with two registered read ports.
// Contents are built at elaboration from bsw_pkg::sine_q30.
module bsw_saw_rom #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned HARMONICS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]        addr_a_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]        addr_b_i,
  output logic signed [bsw_pkg::SAMPLE_W-1:0]  data_a_o,
  output logic signed [bsw_pkg::SAMPLE_W-1:0]  data_b_o
);

  localparam int unsigned AW     = $clog2(TABLE_SIZE);
  localparam int unsigned FRAC_W = bsw_pkg::PHASE_W - AW;

  typedef logic signed [bsw_pkg::SAMPLE_W-1:0] rom_t [TABLE_SIZE];

  // Sum of harmonics weighted 1/k, rounded to Q2.14 and saturated
  function automatic rom_t build_rom();
    rom_t    rom;
    longint  sum;
    longint  s;
    longint  mag;
    longint  q;
    longint  v;
    longint  m;
    longint unsigned rem;
    longint unsigned quo;
    longint unsigned recip [HARMONICS];
    logic [bsw_pkg::PHASE_W-1:0] p;
    // Reciprocal floor(2^32 / k) of each harmonic number, shift and subtract
    for (int unsigned K = 1; K <= HARMONICS; K++) begin
      rem = 0;
      quo = 0;
      for (int B = bsw_pkg::PHASE_W; B >= 0; B--) begin
        rem = (rem << 1) | ((B == bsw_pkg::PHASE_W) ? 64'd1 : 64'd0);
        if (rem >= 64'(K)) begin
          rem = rem - 64'(K);
          quo = quo | (64'd1 << B);
        end
      end
      recip[K-1] = quo;
    end
    for (int unsigned I = 0; I < TABLE_SIZE; I++) begin
      sum = 0;
      for (int unsigned K = 1; K <= HARMONICS; K++) begin
        m   = (longint'(I) * longint'(K)) % TABLE_SIZE;
        p   = bsw_pkg::PHASE_W'(m << FRAC_W);
        s   = bsw_pkg::sine_q30(p);
        mag = (s < 0) ? -s : s;
        // Truncated magnitude over k: the reciprocal estimate is at most one short
        q   = longint'((unsigned'(mag) * recip[K-1]) >> bsw_pkg::PHASE_W);
        if ((q + 1) * longint'(K) <= mag) begin
          q = q + 1;
        end
        sum = (s < 0) ? (sum - q) : (sum + q);
      end
      v = (sum + 64'sd32768) >>> 16;
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      if (v < -64'sd32768) begin
        v = -64'sd32768;
      end
      rom[I] = bsw_pkg::SAMPLE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SAW_ROM = build_rom();

  // Read both neighbors; hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_a_o <= SAW_ROM[addr_a_i];
      data_b_o <= SAW_ROM[addr_b_i];
    end
  end

endmodule

@@ design/bsw_phase.sv @@
// Input register, phase-step multiply and 32-bit phase accumulator.
// Produces the table addresses and interpolation fraction; uses bsw_pkg.
module bsw_phase #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  bsw_pkg::func_e                           func_i,
  input  logic signed [bsw_pkg::FREQ_W-1:0]        freq_hz_i,
  input  logic [bsw_pkg::PSET_W-1:0]               phase_set_i,
  input  logic [bsw_pkg::PPH_W-1:0]                pph_i,
  input  bsw_pkg::stage_t                          stage_i,
  output logic                                     in_ready_o,
  output logic                                     load_o,
  output logic [$clog2(TABLE_SIZE)-1:0]            addr_a_o,
  output logic [$clog2(TABLE_SIZE)-1:0]            addr_b_o,
  output logic [bsw_pkg::PHASE_W-$clog2(TABLE_SIZE)-1:0] frac_o
);

  localparam int unsigned AW     = $clog2(TABLE_SIZE);
  localparam int unsigned FRAC_W = bsw_pkg::PHASE_W - AW;
  localparam int unsigned PROD_W = bsw_pkg::FREQ_W + bsw_pkg::PPH_W + 1;

  logic                              s1_v_q;
  bsw_pkg::func_e                    func_q;
  logic [bsw_pkg::PHASE_W-1:0]       step_q;
  logic [bsw_pkg::PHASE_W-1:0]       step_d;
  logic [bsw_pkg::PSET_W-1:0]        pset_q;
  logic [bsw_pkg::PHASE_W-1:0]       acc_q;
  logic [bsw_pkg::PHASE_W-1:0]       acc_d;
  logic signed [PROD_W-1:0]          prod;
  logic                              accept;
  logic                              fire;

  // Phase step: signed frequency times unsigned rate, floored by 2^8
  assign prod   = freq_hz_i * $signed({1'b0, pph_i});
  assign step_d = prod[bsw_pkg::PHASE_W+7:8];

  assign in_ready_o = !s1_v_q || stage_i.ready;
  assign accept     = valid_i && in_ready_o;
  assign fire       = s1_v_q && stage_i.ready;
  assign load_o     = fire && (func_q == bsw_pkg::FUNC_SAMPLE);

  // Advance stage-one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= valid_i;
    end
  end

  // Capture the word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      step_q <= step_d;
      pset_q <= phase_set_i;
    end
  end

  // Accumulate or load the phase as the word leaves stage one
  always_comb begin
    acc_d = acc_q;
    if (fire) begin
      if (func_q == bsw_pkg::FUNC_SET_PHASE) begin
        acc_d = {pset_q, 8'd0};
      end else begin
        acc_d = acc_q + step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Index from the top bits, neighbor wraps to entry zero
  assign addr_a_o = acc_q[bsw_pkg::PHASE_W-1 -: AW];
  assign addr_b_o = AW'(addr_a_o + 1'b1);
  assign frac_o   = acc_q[FRAC_W-1:0];

endmodule

@@ design/bsw_interp.sv @@
// Linear interpolation between two table entries and the output register.
// Uses bsw_pkg for widths and the stage status struct.
module bsw_interp #(
  parameter int unsigned FRAC_W = 22
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [FRAC_W-1:0]                     frac_i,
  input  logic signed [bsw_pkg::SAMPLE_W-1:0]   a_i,
  input  logic signed [bsw_pkg::SAMPLE_W-1:0]   b_i,
  input  logic                                  stall_i,
  output bsw_pkg::stage_t                       stage_o,
  output logic                                  valid_o,
  output logic signed [bsw_pkg::SAMPLE_W-1:0]   sample_o
);

  localparam int unsigned DIFF_W = bsw_pkg::SAMPLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + FRAC_W + 1;
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;

  logic                                s2_v_q;
  logic [FRAC_W-1:0]                   frac_q;
  logic                                out_v_q;
  logic signed [bsw_pkg::SAMPLE_W-1:0] sample_q;
  logic                                out_ready;
  logic                                s2_ready;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [PROD_W-1:0]            prod;
  logic signed [SUM_W-1:0]             y_wide;

  assign out_ready = !out_v_q || !stall_i;
  assign s2_ready  = !s2_v_q || out_ready;

  assign stage_o.s2_valid = s2_v_q;
  assign stage_o.ready    = s2_ready;

  // Advance stage-two valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= load_i;
    end
  end

  // Hold the fraction alongside the table data
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frac_q <= frac_i;
    end
  end

  // a + floor((b - a) * frac / 2^FRAC_W)
  assign diff   = $signed({b_i[bsw_pkg::SAMPLE_W-1], b_i})
                - $signed({a_i[bsw_pkg::SAMPLE_W-1], a_i});
  assign prod   = diff * $signed({1'b0, frac_q});
  assign y_wide = SUM_W'(a_i) + prod[PROD_W-1:FRAC_W];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_v_q) begin
      sample_q <= y_wide[bsw_pkg::SAMPLE_W-1:0];
    end
  end

  assign valid_o  = out_v_q;
  assign sample_o = sample_q;

endmodule

@@ verif/bsw_checker.sv @@
// Checker for the band-limited saw oscillator: watches the request, sample and
// register ports, predicts every sample from its own wavetable and phase copy.
// Depends on bsw_pkg for widths and the func_e codes.
module bsw_checker #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned HARMONICS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  bsw_pkg::func_e                       func_i,
  input  logic signed [bsw_pkg::FREQ_W-1:0]    freq_hz_i,
  input  logic [bsw_pkg::PSET_W-1:0]           phase_set_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [bsw_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 cfg_we_i,
  input  logic [bsw_pkg::PPH_W-1:0]            cfg_wdata_i,
  output int                                   pending_o,
  output int                                   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POLY_A   = 64'd1686629713;
  localparam longint unsigned POLY_B   = 64'd688904866;
  localparam longint unsigned POLY_C   = 64'd76016977;
  localparam longint unsigned UNIT_Q30 = 64'd1073741824;
  localparam logic [bsw_pkg::PPH_W-1:0] STEP_PER_HZ_DEFAULT = 24'd89478;
  localparam int MAX_PRINTED = 40;

  logic signed [bsw_pkg::SAMPLE_W-1:0] saw_rom [TABLE_SIZE];
  logic [bsw_pkg::PHASE_W-1:0]         phase;
  logic [bsw_pkg::PPH_W-1:0]           step_per_hz;
  logic signed [bsw_pkg::SAMPLE_W-1:0] sample_q [$];
  int                                  mismatches = 0;

  assign errors_o = mismatches;

  // Q30 sine: fold into a quarter wave, odd polynomial, sign from the half
  function automatic longint sine_q30_of(input logic [31:0] p);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x = longint'(p & 32'h3FFF_FFFF);
    if (p[30]) begin
      x = UNIT_Q30 - x;
    end
    x2 = (x * x) >> 30;
    t  = POLY_A - (((POLY_B - ((POLY_C * x2) >> 30)) * x2) >> 30);
    t  = (t * x) >> 30;
    return p[31] ? -longint'(t) : longint'(t);
  endfunction

  // Fill the wavetable: harmonics weighted 1/k, rounded to Q2.14, saturated
  initial begin : fill_rom
    longint          sum_q30;
    longint          s;
    longint          q;
    longint unsigned m;
    longint unsigned p;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      sum_q30 = 0;
      for (int k = 1; k <= HARMONICS; k++) begin
        m = (longint'(i) * longint'(k)) % TABLE_SIZE;
        p = (m << 32) / TABLE_SIZE;
        s = sine_q30_of(p[31:0]);
        q = (s < 0 ? -s : s) / longint'(k);
        sum_q30 += (s < 0) ? -q : q;
      end
      sum_q30 = (sum_q30 + 32768) >>> 16;
      if (sum_q30 > 32767) begin
        sum_q30 = 32767;
      end
      if (sum_q30 < -32768) begin
        sum_q30 = -32768;
      end
      saw_rom[i] = sum_q30[15:0];
    end
  end

  // Interpolate between the entry at the phase and its wrapped neighbor
  function automatic logic signed [bsw_pkg::SAMPLE_W-1:0] saw_at(
      input logic [bsw_pkg::PHASE_W-1:0] ph);
    longint unsigned pos;
    longint          a;
    longint          b;
    longint          frac;
    longint          y;
    int unsigned     idx;
    pos  = {32'd0, ph} * longint'(TABLE_SIZE);
    idx  = int'((pos >> 32) % TABLE_SIZE);
    a    = saw_rom[idx];
    b    = saw_rom[(idx + 1) % TABLE_SIZE];
    frac = longint'({32'd0, pos[31:0]});
    y    = a + (((b - a) * frac) >>> 32);
    return y[bsw_pkg::SAMPLE_W-1:0];
  endfunction

  // Phase advance: signed Hz times step per Hz, floored by 8 bits, mod 2^32
  function automatic logic [bsw_pkg::PHASE_W-1:0] phase_step(
      input logic signed [bsw_pkg::FREQ_W-1:0] f,
      input logic [bsw_pkg::PPH_W-1:0] k);
    longint prod;
    prod = longint'(f) * longint'({40'd0, k});
    return prod[39:8];
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // Track register writes, predict on accepted requests, compare on accepted samples
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [bsw_pkg::SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      phase       = '0;
      step_per_hz = STEP_PER_HZ_DEFAULT;
      sample_q.delete();
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        step_per_hz = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          report($sformatf("sample word %0d with no request waiting", sample_i));
        end else begin
          want = sample_q.pop_front();
          if (sample_i !== want) begin
            report($sformatf("sample got %0d want %0d", sample_i, want));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == bsw_pkg::FUNC_SET_PHASE) begin
          phase = {phase_set_i, 8'd0};
        end else begin
          sample_q.push_back(saw_at(phase));
          phase = phase + phase_step(freq_hz_i, step_per_hz);
        end
      end
      pending_o <= sample_q.size();
    end
  end

endmodule

@@ verif/bandlimited_saw_wavetable_osc_test.sv @@
// Top of the saw oscillator testbench: clock, reset, request and register
// stimulus, random output stall and the verdict. Uses bsw_pkg and bsw_checker.
module bandlimited_saw_wavetable_osc_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned HARMONICS  = 32;
  localparam int IDLE_PCT       = 15;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 185;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 valid_i     = 1'b0;
  logic                                 stall_o;
  bsw_pkg::func_e                       func_i      = bsw_pkg::FUNC_SAMPLE;
  logic signed [bsw_pkg::FREQ_W-1:0]    freq_hz_i   = '0;
  logic [bsw_pkg::PSET_W-1:0]           phase_set_i = '0;
  logic                                 valid_o;
  logic                                 stall_i     = 1'b0;
  logic signed [bsw_pkg::SAMPLE_W-1:0]  sample_o;
  logic                                 cfg_we_i    = 1'b0;
  logic [bsw_pkg::PPH_W-1:0]            cfg_wdata_i = '0;

  int          pending;
  int          fail_count;
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  bandlimited_saw_wavetable_osc #(
    .TABLE_SIZE (TABLE_SIZE),
    .HARMONICS  (HARMONICS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .func_i      (func_i),
    .freq_hz_i   (freq_hz_i),
    .phase_set_i (phase_set_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .sample_o    (sample_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bsw_checker #(
    .TABLE_SIZE (TABLE_SIZE),
    .HARMONICS  (HARMONICS)
  ) sample_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_i  (stall_o),
    .func_i      (func_i),
    .freq_hz_i   (freq_hz_i),
    .phase_set_i (phase_set_i),
    .out_valid_i (valid_o),
    .out_stall_i (stall_i),
    .sample_i    (sample_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (fail_count)
  );

  // Stall the sample side at random, or hold it off for a long stretch on request
  initial begin : sample_sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        stall_i <= 1'b0;
      end else begin
        stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word and hold it until accepted; valid stays high afterwards
  task automatic put_word(input bsw_pkg::func_e op,
                          input logic [bsw_pkg::FREQ_W-1:0] freq_bits,
                          input logic [bsw_pkg::PSET_W-1:0] pset);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    func_i      <= op;
    freq_hz_i   <= freq_bits;
    phase_set_i <= pset;
    do @(posedge clk_i); while (stall_o);
  endtask

  // Drop valid, wait for every sample, then let the pipeline empty
  task automatic settle();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step_per_hz(input logic [bsw_pkg::PPH_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random word: mostly samples over a spread of frequencies, some phase loads
  task automatic random_word();
    logic [bsw_pkg::FREQ_W-1:0] f;
    logic [bsw_pkg::PSET_W-1:0] ps;
    ps = bsw_pkg::PSET_W'($urandom());
    case ($urandom_range(3))
      0:       f = bsw_pkg::FREQ_W'($urandom());
      1:       f = bsw_pkg::FREQ_W'($urandom_range(8191) - 4096);
      2:       f = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: f = bsw_pkg::FREQ_W'($urandom_range(10240000) - 5120000);
    endcase
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(3) == 0) begin
        ps = 24'hFFFF00 | ps[7:0];
      end
      put_word(bsw_pkg::FUNC_SET_PHASE, f, ps);
    end else begin
      put_word(bsw_pkg::FUNC_SAMPLE, f, ps);
    end
  endtask

  initial begin : stimulus
    logic [bsw_pkg::PPH_W-1:0] settings [6];
    settings = '{24'hFFFFFF, 24'd0, 24'd89478, 24'd1, 24'h000000, 24'h000000};
    settings[4] = bsw_pkg::PPH_W'($urandom());
    settings[5] = bsw_pkg::PPH_W'($urandom_range(200000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: phase zero, frequency extremes, table wrap, ignored fields
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h000000, 24'hFFFFFF);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h7FFFFF, 24'h000000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h800000, 24'h000000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'hFFFFFF, 24'h5A5A5A);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'hA5A5A5, 24'hFFFFFF);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h000000, 24'h000000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h000001, 24'hFFFFFF);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'hFFFFFF, 24'h000000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h000000, 24'hFFFFFF);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'h000000, 24'h800000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h123456, 24'h000000);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'h7FFFFF, 24'h400000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'hEDCBAA, 24'h3C3C3C);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'h800000, 24'h3FFFFF);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h000000, 24'hC3C3C3);
    put_word(bsw_pkg::FUNC_SET_PHASE, 24'h000000, 24'hFFFFC0);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h7FFFFF, 24'h000000);
    put_word(bsw_pkg::FUNC_SAMPLE,    24'h800000, 24'h000000);
    settle();

    // Random phases, one register setting each
    foreach (settings[s]) begin
      write_step_per_hz(settings[s]);
      calm = (s == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (s == 3 && n == 60) begin
          hold_req = 1'b1;
        end
        random_word();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
